// File: sv/s2a_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
package s2a_pkg;

    localparam int WIDTH           = 32;
    localparam int DIGITS          = 10;
    localparam int BCD_W           = 4 * DIGITS;
    localparam int DIG_IDX_W       = $clog2(DIGITS);
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES      = WIDTH / STEPS_PER_STAGE;

    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] CHAR_ZERO  = 6'd48;

    // Conversion state carried down the shift-and-add-3 pipeline
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [WIDTH-1:0] bin;
    } conv_t;

endpackage

// File: sv/s2a_dabble_stage.sv
// One pipeline stage of the binary to BCD converter: a few shift-and-add-3 steps.
module s2a_dabble_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  s2a_pkg::conv_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output s2a_pkg::conv_t out_data
);

    logic           valid_reg;
    logic           valid_next;
    s2a_pkg::conv_t data_reg;
    s2a_pkg::conv_t data_next;
    logic           load;

    // Shift-and-add-3 steps for this stage
    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < s2a_pkg::STEPS_PER_STAGE; s++)
        begin
            for (int d = 0; d < s2a_pkg::DIGITS; d++)
            begin
                if (data_next.bcd[4*d +: 4] >= 4'd5)
                begin
                    data_next.bcd[4*d +: 4] = data_next.bcd[4*d +: 4] + 4'd3;
                end
            end
            data_next.bcd = {data_next.bcd[s2a_pkg::BCD_W-2:0],
                             data_next.bin[s2a_pkg::WIDTH-1]};
            data_next.bin = {data_next.bin[s2a_pkg::WIDTH-2:0], 1'b0};
        end
    end

    // Stage advances when empty or when downstream takes the transfer
    assign load       = !valid_reg || !out_stall;
    assign in_stall   = !load;
    assign valid_next = load ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: sv/s2a_serializer.sv
// Serializer: emits sign and significant BCD digits as ASCII, one per cycle while the receiver does not stall.
module s2a_serializer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  s2a_pkg::conv_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [5:0]     character,
    output logic           last
);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           neg_pend_reg;
    logic                           neg_pend_next;
    logic [s2a_pkg::DIG_IDX_W-1:0]  idx_reg;
    logic [s2a_pkg::DIG_IDX_W-1:0]  idx_next;
    logic [3:0]                     digits_reg [s2a_pkg::DIGITS];
    logic [s2a_pkg::DIG_IDX_W-1:0]  top_idx;
    logic                           advance;
    logic                           finish;
    logic                           load;

    // Highest nonzero digit; zero gives a single digit
    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < s2a_pkg::DIGITS; d++)
        begin
            if (in_data.bcd[4*d +: 4] != 4'd0)
            begin
                top_idx = s2a_pkg::DIG_IDX_W'(d);
            end
        end
    end

    // Output from registered state
    assign out_valid = busy_reg;
    assign character = neg_pend_reg ? s2a_pkg::CHAR_MINUS
                                    : s2a_pkg::CHAR_ZERO + {2'b00, digits_reg[idx_reg]};
    assign last      = !neg_pend_reg && (idx_reg == '0);

    assign advance  = busy_reg && !out_stall;
    assign finish   = advance && last;
    assign load     = !busy_reg || finish;
    assign in_stall = !load;

    // Sequencing of sign and digits
    always_comb
    begin
        busy_next     = busy_reg;
        neg_pend_next = neg_pend_reg;
        idx_next      = idx_reg;
        if (load)
        begin
            busy_next     = in_valid;
            neg_pend_next = in_data.neg;
            idx_next      = top_idx;
        end
        else if (advance)
        begin
            if (neg_pend_reg)
            begin
                neg_pend_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - s2a_pkg::DIG_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            neg_pend_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            neg_pend_reg <= neg_pend_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            for (int d = 0; d < s2a_pkg::DIGITS; d++)
            begin
                digits_reg[d] <= in_data.bcd[4*d +: 4];
            end
        end
    end

    // Only a minus sign or a decimal digit leaves the block
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == s2a_pkg::CHAR_MINUS) ||
                      (character >= s2a_pkg::CHAR_ZERO && character <= 6'd57))
        else $error("character out of range");

    // A minus sign is always followed by at least one digit
    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && neg_pend_reg) |=> (busy_reg && !neg_pend_reg))
        else $error("minus sign not followed by digit");

    // After the last transfer with nothing waiting, the serializer goes idle
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && !in_valid) |=> !busy_reg)
        else $error("serializer busy after last character");

endmodule

// File: sv/signed_int_to_decimal_ascii.sv
// An input transfer reaches its first character through the input register, eight conversion
// stages of four shift-and-add-3 steps each, and the serializer load.
// Throughput: one character per cycle unless the receiver stalls; an item gives 1 to 11
// characters (its digits plus one for a minus sign), set by the single-character output serializer.
// The conversion pipeline accepts a new value every cycle until it backs up.
// Reset (rst_n, async, active low) empties every stage and the serializer.
module signed_int_to_decimal_ascii
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    output logic        value_stall,
    input  logic [31:0] value,
    output logic        character_valid,
    input  logic        character_stall,
    output logic [5:0]  character,
    output logic        last
);

    logic           valid_reg;
    s2a_pkg::conv_t data_reg;
    s2a_pkg::conv_t data_next;
    logic           load;

    logic           stg_valid [s2a_pkg::NUM_STAGES+1];
    logic           stg_stall [s2a_pkg::NUM_STAGES+1];
    s2a_pkg::conv_t stg_data  [s2a_pkg::NUM_STAGES+1];

    // Input stage: sign and magnitude (unsigned, so the most negative value is safe)
    always_comb
    begin
        data_next.neg = value[s2a_pkg::WIDTH-1];
        data_next.bcd = '0;
        data_next.bin = value[s2a_pkg::WIDTH-1] ? (~value + 32'd1) : value;
    end

    assign load        = !valid_reg || !stg_stall[0];
    assign value_stall = !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= value_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && value_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign stg_valid[0] = valid_reg;
    assign stg_data[0]  = data_reg;

    // Binary to BCD pipeline
    for (genvar g = 0; g < s2a_pkg::NUM_STAGES; g++)
    begin : g_stage
        s2a_dabble_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_stall  (stg_stall[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_stall (stg_stall[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    // Character output
    s2a_serializer u_serializer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[s2a_pkg::NUM_STAGES]),
        .in_stall  (stg_stall[s2a_pkg::NUM_STAGES]),
        .in_data   (stg_data[s2a_pkg::NUM_STAGES]),
        .out_valid (character_valid),
        .out_stall (character_stall),
        .character (character),
        .last      (last)
    );

endmodule

// File: sim/tb_signed_int_to_decimal_ascii.sv
// Testbench for the signed integer to decimal ASCII converter: directed table plus random values.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    localparam int RANDOM_ITEMS = 110;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 30;

    // One expected output character
    typedef struct packed {
        logic [5:0] code;
        logic       tail;
    } ascii_char_t;

    // Directed row: text left empty means the predictor supplies the characters
    typedef struct {
        logic [31:0] num;
        string       text;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        value_valid;
    logic        value_stall;
    logic [31:0] value;
    logic        character_valid;
    logic        character_stall;
    logic [5:0]  character;
    logic        last;

    ascii_char_t pending_chars[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          no_gaps;

    signed_int_to_decimal_ascii dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .value_valid     (value_valid),
        .value_stall     (value_stall),
        .value           (value),
        .character_valid (character_valid),
        .character_stall (character_stall),
        .character       (character),
        .last            (last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Predicted decimal text of a 32-bit two's complement value
    function automatic void expect_decimal(input logic [31:0] num);
        logic [31:0] mag;
        logic [3:0]  digs[10];
        int          nd;
        ascii_char_t item;
        mag = num[31] ? (~num + 32'd1) : num;
        nd  = 0;
        do
        begin
            digs[nd] = 4'(mag % 32'd10);
            mag      = mag / 32'd10;
            nd++;
        end
        while (mag != 32'd0 && nd < 10);
        if (num[31])
        begin
            item.code = s2a_pkg::CHAR_MINUS;
            item.tail = 1'b0;
            pending_chars.push_back(item);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            item.code = 6'(s2a_pkg::CHAR_ZERO + 6'(digs[i]));
            item.tail = (i == 0);
            pending_chars.push_back(item);
        end
    endfunction

    // Expected characters typed in as text
    function automatic void expect_text(input string s);
        byte         ch;
        ascii_char_t item;
        for (int i = 0; i < s.len(); i++)
        begin
            ch        = s[i];
            item.code = ch[5:0];
            item.tail = (i == s.len() - 1);
            pending_chars.push_back(item);
        end
    endfunction

    // Offer one value after a random gap (none while no_gaps is set); expectations are queued on the transfer
    task automatic send_value(input logic [31:0] num, input string text);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            value_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        value       <= num;
        value_valid <= 1'b1;
        do
            @(posedge clk);
        while (value_stall);
        if (text.len() != 0)
            expect_text(text);
        else
            expect_decimal(num);
    endtask

    // Random value, biased toward every digit count and the range ends
    function automatic logic [31:0] pick_value();
        longint lo;
        longint hi;
        longint mag;
        int     d;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1:
            begin
                d  = $urandom_range(1, 10);
                lo = (d == 1) ? 0 : 64'd10 ** (d - 1);
                hi = (d == 10) ? 64'd2147483647 : (64'd10 ** d) - 1;
                mag = lo + ($urandom % (hi - lo + 1));
                return $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
            end
            2:
            begin
                mag = $urandom_range(0, 20);
                return $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
            end
            default:
                return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
                                            : 32'h7FFF_FFFF - $urandom_range(0, 15);
        endcase
    endfunction

    // Receiver stall pattern: a random hold before each character transfer (none while no_gaps is set)
    initial
    begin
        int n;
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 6);
            if (n > 0)
            begin
                character_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            character_stall <= 1'b0;
            do
                @(posedge clk);
            while (!character_valid);
        end
    end

    // Check each character transfer against the oldest expectation
    always @(posedge clk)
    begin
        ascii_char_t want;
        if (rst_n && character_valid && !character_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("character: unexpected transfer, got %0d last %0d", character, last);
                mismatch_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (character !== want.code)
                begin
                    $error("character: expected %0d, got %0d", want.code, character);
                    mismatch_count++;
                end
                if (last !== want.tail)
                begin
                    $error("last: expected %0d, got %0d", want.tail, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_signed_int_to_decimal_ascii: done, errors");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t directed_rows[21];
        no_gaps         = 1'b0;
        rst_n           = 1'b0;
        value_valid     = 1'b0;
        value           = 32'd0;

        directed_rows = '{
            '{32'd0,          "0"},
            '{32'd1,          "1"},
            '{-32'sd1,        "-1"},
            '{32'd9,          "9"},
            '{32'd10,         "10"},
            '{-32'sd10,       "-10"},
            '{-32'sd7,        "-7"},
            '{32'd99,         ""},
            '{32'd100,        ""},
            '{-32'sd100,      ""},
            '{32'h7FFF_FFFF,  "2147483647"},
            '{32'h8000_0000,  "-2147483648"},
            '{32'h8000_0001,  "-2147483647"},
            '{32'd1000000000, "1000000000"},
            '{32'd999999999,  ""},
            '{-32'sd999999999, ""},
            '{32'h5555_5555,  ""},
            '{32'hAAAA_AAAA,  ""},
            '{32'd12345,      ""},
            '{32'd1234567890, ""},
            '{-32'sd1234567890, ""}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i])
            send_value(directed_rows[i].num, directed_rows[i].text);

        // Random values, with a back-to-back stretch in the middle
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_gaps = (i >= 40 && i < 70);
            send_value(pick_value(), "");
        end
        no_gaps = 1'b0;
        value_valid <= 1'b0;

        // Drain, then let any stray characters show up
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("tb_signed_int_to_decimal_ascii: done, clean");
        else
            $display("tb_signed_int_to_decimal_ascii: done, errors");
        $finish;
    end

endmodule

// File: signed_int_to_decimal_ascii.f
sv/s2a_pkg.sv
sv/s2a_dabble_stage.sv
sv/s2a_serializer.sv
sv/signed_int_to_decimal_ascii.sv
sim/tb_signed_int_to_decimal_ascii.sv
